// ===== sv/ppas_pkg.sv =====
package ppas_pkg;

    // Event codes carried in the operation field.
    localparam logic [2:0] OP_TICK        = 3'd0;
    localparam logic [2:0] OP_START       = 3'd1;
    localparam logic [2:0] OP_CONTINUE    = 3'd2;
    localparam logic [2:0] OP_ABORT       = 3'd3;
    localparam logic [2:0] OP_ROTATE_OUT  = 3'd4;
    localparam logic [2:0] OP_ROTATE_BACK = 3'd5;
    localparam logic [2:0] OP_PUMP_TOGGLE = 3'd6;

    // Catch height codes.
    localparam logic [1:0] LEVEL_LOW     = 2'd0;
    localparam logic [1:0] LEVEL_MID     = 2'd1;
    localparam logic [1:0] LEVEL_HIGH    = 2'd2;
    localparam logic [1:0] LEVEL_INVALID = 2'd3;

    // Dwell register indexes on the configuration port.
    localparam logic [2:0] CFG_WAIT_ROTATE       = 3'd0;
    localparam logic [2:0] CFG_WAIT_HEIGHT       = 3'd1;
    localparam logic [2:0] CFG_WAIT_PUSH         = 3'd2;
    localparam logic [2:0] CFG_WAIT_BACK         = 3'd3;
    localparam logic [2:0] CFG_WAIT_TURN_RELEASE = 3'd4;
    localparam logic [2:0] CFG_WAIT_TURN_TOTAL   = 3'd5;
    localparam logic [2:0] CFG_WAIT_DROP         = 3'd6;
    localparam logic [2:0] CFG_WAIT_HOME         = 3'd7;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // Dwell reset values in milliseconds.
    localparam logic [CFG_W-1:0] WAIT_DEFAULT_MS      = 16'd500;
    localparam logic [CFG_W-1:0] WAIT_TURN_RELEASE_MS = 16'd800;
    localparam logic [CFG_W-1:0] WAIT_TURN_TOTAL_MS   = 16'd2000;
    localparam logic [CFG_W-1:0] WAIT_HOME_MS         = 16'd2000;

    // Setpoints in whole degrees.
    localparam logic signed [15:0] DEG_LOW       = -16'sd1300;
    localparam logic signed [15:0] DEG_MID       = -16'sd707;
    localparam logic signed [15:0] DEG_HIGH      = 16'sd0;
    localparam logic signed [15:0] DEG_RELEASE_H = -16'sd150;
    localparam logic signed [15:0] DEG_ROT_OUT   = -16'sd300;
    localparam logic signed [15:0] DEG_ROT_REL   = 16'sd60;
    localparam logic signed [15:0] DEG_PUSH      = 16'sd80;
    localparam logic signed [15:0] DEG_RETRACT   = 16'sd20;
    localparam logic signed [15:0] DEG_ZERO      = 16'sd0;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] now_ms;
        logic [1:0]  level;
    } t_in_item;

    typedef struct packed {
        logic               accepted;
        logic               busy_res;
        logic [3:0]         step_code;
        logic               rotate_enable;
        logic signed [15:0] rotate_ref;
        logic               height_enable;
        logic signed [15:0] height_ref;
        logic               catch_enable;
        logic signed [15:0] catch_ref;
        logic               valve_open;
        logic               pump_on;
    } t_out_item;

endpackage

// ===== sv/pick_place_arm_sequencer.sv =====
// Pick-and-place arm sequencer.
// Input channel (i_in_valid / o_in_ready / i_in) carries one event per transfer:
// a tick, start with a catch level, continue, abort, rotate out, rotate back or
// pump toggle, each stamped with a millisecond time. Every event produces exactly
// one result on the output channel (o_out_valid / i_out_ready / o_out) holding
// the actuator commands, the step code, busy and whether a start was taken.
// The result is registered: the sequencer state and the result register load at
// the edge that takes the event. Throughput is one event per cycle while the
// receiver takes results; the only work per event is one 32-bit elapsed-time
// subtract and two compares against the dwells of the current step. The result
// register frees in the same cycle it is taken. When the receiver stalls, the
// pending result holds and o_in_ready drops until it is taken. The user must write
// dwell registers through i_cfg_we / i_cfg_index / i_cfg_data only while no event
// is in flight; the block does not enforce it. Reset returns the step to idle,
// loads the default dwells and clears the commands (rotation loop enabled at zero).
module pick_place_arm_sequencer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  ppas_pkg::t_in_item         i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output ppas_pkg::t_out_item        o_out,
    input  logic                       i_cfg_we,
    input  logic [ppas_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ppas_pkg::CFG_W-1:0] i_cfg_data
);
    import ppas_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'd0,
        ST_ROTATE  = 4'd1,
        ST_HEIGHT  = 4'd2,
        ST_PUSH    = 4'd3,
        ST_RETRACT = 4'd4,
        ST_HBACK   = 4'd5,
        ST_TURN    = 4'd6,
        ST_RELEASE = 4'd7,
        ST_HOME    = 4'd8
    } t_step;

    // Dwell registers.
    logic [CFG_W-1:0] r_wait_rotate, r_wait_height, r_wait_push, r_wait_back;
    logic [CFG_W-1:0] r_wait_turn_release, r_wait_turn_total, r_wait_drop, r_wait_home;

    // Sequencer state and latched commands.
    t_step              r_step, n_step;
    logic [31:0]        r_start, n_start;
    logic [1:0]         r_level, n_level;
    logic               r_cont, n_cont;
    logic               r_rot_out, n_rot_out;
    logic               r_toggle, n_toggle;
    logic               r_rot_en, n_rot_en;
    logic signed [15:0] r_rot_ref, n_rot_ref;
    logic               r_hgt_en, n_hgt_en;
    logic signed [15:0] r_hgt_ref, n_hgt_ref;
    logic               r_cat_en, n_cat_en;
    logic signed [15:0] r_cat_ref, n_cat_ref;
    logic               r_valve, n_valve;
    logic               r_relay, n_relay;
    logic               n_accepted;

    // Result register.
    logic      r_out_valid;
    t_out_item r_out;

    logic             in_fire;
    logic [31:0]      elapsed_ms;
    logic [CFG_W-1:0] wait_sel;
    logic             el_main;
    logic             el_total;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Time in the current step, modulo 2^32, against the dwell of that step.
    assign elapsed_ms = i_in.now_ms - r_start;

    always_comb begin
        unique case (r_step)
            ST_ROTATE:           wait_sel = r_wait_rotate;
            ST_HEIGHT:           wait_sel = r_wait_height;
            ST_PUSH:             wait_sel = r_wait_push;
            ST_RETRACT, ST_HBACK: wait_sel = r_wait_back;
            ST_TURN:             wait_sel = r_wait_turn_release;
            ST_RELEASE:          wait_sel = r_wait_drop;
            ST_HOME:             wait_sel = r_wait_home;
            default:             wait_sel = '0;
        endcase
    end

    assign el_main  = elapsed_ms >= {16'd0, wait_sel};
    assign el_total = elapsed_ms >= {16'd0, r_wait_turn_total};

    // Next state and commands for the event at the input.
    always_comb begin
        n_step     = r_step;
        n_start    = r_start;
        n_level    = r_level;
        n_cont     = r_cont;
        n_rot_out  = r_rot_out;
        n_toggle   = r_toggle;
        n_rot_en   = r_rot_en;
        n_rot_ref  = r_rot_ref;
        n_hgt_en   = r_hgt_en;
        n_hgt_ref  = r_hgt_ref;
        n_cat_en   = r_cat_en;
        n_cat_ref  = r_cat_ref;
        n_valve    = r_valve;
        n_relay    = r_relay;
        n_accepted = 1'b0;

        unique case (i_in.operation)
            OP_TICK: begin
                unique case (r_step)
                    ST_IDLE: begin
                        n_cat_en  = 1'b1;
                        n_cat_ref = DEG_ZERO;
                    end
                    ST_ROTATE: begin
                        n_rot_en  = 1'b1;
                        n_rot_ref = DEG_ROT_OUT;
                        // Already rotated out skips the dwell.
                        if (r_rot_out || el_main) begin
                            n_step  = ST_HEIGHT;
                            n_start = i_in.now_ms;
                        end
                    end
                    ST_HEIGHT: begin
                        n_hgt_en = 1'b1;
                        n_valve  = 1'b0;
                        n_relay  = 1'b1;
                        unique case (r_level)
                            LEVEL_LOW:  n_hgt_ref = DEG_LOW;
                            LEVEL_MID:  n_hgt_ref = DEG_MID;
                            LEVEL_HIGH: n_hgt_ref = DEG_HIGH;
                            default:    n_hgt_ref = r_hgt_ref;
                        endcase
                        if (el_main) begin
                            n_step  = ST_PUSH;
                            n_start = i_in.now_ms;
                        end
                    end
                    ST_PUSH: begin
                        n_cat_en  = 1'b1;
                        n_cat_ref = DEG_PUSH;
                        if (el_main) begin
                            n_step  = ST_RETRACT;
                            n_start = i_in.now_ms;
                            n_cont  = 1'b0;
                        end
                    end
                    ST_RETRACT: begin
                        n_cat_en  = 1'b1;
                        n_cat_ref = DEG_RETRACT;
                        if (el_main) begin
                            n_step  = ST_HBACK;
                            n_start = i_in.now_ms;
                        end
                    end
                    ST_HBACK: begin
                        n_hgt_en  = 1'b1;
                        n_hgt_ref = DEG_HIGH;
                        if (el_main && r_cont) begin
                            n_cont  = 1'b0;
                            n_step  = ST_TURN;
                            n_start = i_in.now_ms;
                        end
                    end
                    ST_TURN: begin
                        n_rot_en  = 1'b1;
                        n_rot_ref = DEG_ROT_REL;
                        if (el_main) begin
                            n_hgt_en  = 1'b1;
                            n_hgt_ref = DEG_RELEASE_H;
                            if (el_total) begin
                                n_step  = ST_RELEASE;
                                n_start = i_in.now_ms;
                            end
                        end
                    end
                    ST_RELEASE: begin
                        n_cat_en  = 1'b1;
                        n_cat_ref = DEG_RETRACT;
                        n_valve   = 1'b1;
                        n_relay   = 1'b0;
                        // The home step keeps the release entry time.
                        if (el_main) begin
                            n_step = ST_HOME;
                        end
                    end
                    ST_HOME: begin
                        n_cat_en  = 1'b1;
                        n_cat_ref = DEG_ZERO;
                        n_rot_en  = 1'b1;
                        n_rot_ref = DEG_ROT_OUT;
                        n_rot_out = 1'b1;
                        n_hgt_en  = 1'b1;
                        n_hgt_ref = DEG_ZERO;
                        if (el_main) begin
                            n_step  = ST_IDLE;
                            n_start = i_in.now_ms;
                        end
                    end
                    default: begin
                        n_step = r_step;
                    end
                endcase
            end
            OP_START: begin
                if (r_step == ST_IDLE && i_in.level != LEVEL_INVALID) begin
                    n_level    = i_in.level;
                    n_cont     = 1'b0;
                    n_step     = ST_ROTATE;
                    n_start    = i_in.now_ms;
                    n_accepted = 1'b1;
                end
            end
            OP_CONTINUE: begin
                if (r_step == ST_HBACK) begin
                    n_cont = 1'b1;
                end
            end
            OP_ABORT: begin
                // Setpoints, valve, pump and entry time are left as they are.
                if (r_step != ST_IDLE) begin
                    n_cat_en = 1'b0;
                    n_rot_en = 1'b0;
                    n_hgt_en = 1'b0;
                    n_step   = ST_IDLE;
                end
            end
            OP_ROTATE_OUT: begin
                if (!r_rot_out) begin
                    n_rot_en  = 1'b1;
                    n_rot_ref = DEG_ROT_OUT;
                    n_rot_out = 1'b1;
                end
            end
            OP_ROTATE_BACK: begin
                if (r_rot_out) begin
                    n_rot_en  = 1'b1;
                    n_rot_ref = DEG_ZERO;
                    n_rot_out = 1'b0;
                end
            end
            OP_PUMP_TOGGLE: begin
                n_toggle = !r_toggle;
                n_valve  = r_toggle;
                n_relay  = !r_toggle;
            end
            default: begin
                n_accepted = 1'b0;
            end
        endcase
    end

    // Dwell register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_rotate       <= WAIT_DEFAULT_MS;
            r_wait_height       <= WAIT_DEFAULT_MS;
            r_wait_push         <= WAIT_DEFAULT_MS;
            r_wait_back         <= WAIT_DEFAULT_MS;
            r_wait_turn_release <= WAIT_TURN_RELEASE_MS;
            r_wait_turn_total   <= WAIT_TURN_TOTAL_MS;
            r_wait_drop         <= WAIT_DEFAULT_MS;
            r_wait_home         <= WAIT_HOME_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WAIT_ROTATE:       r_wait_rotate       <= i_cfg_data;
                CFG_WAIT_HEIGHT:       r_wait_height       <= i_cfg_data;
                CFG_WAIT_PUSH:         r_wait_push         <= i_cfg_data;
                CFG_WAIT_BACK:         r_wait_back         <= i_cfg_data;
                CFG_WAIT_TURN_RELEASE: r_wait_turn_release <= i_cfg_data;
                CFG_WAIT_TURN_TOTAL:   r_wait_turn_total   <= i_cfg_data;
                CFG_WAIT_DROP:         r_wait_drop         <= i_cfg_data;
                CFG_WAIT_HOME:         r_wait_home         <= i_cfg_data;
                default:               r_wait_home         <= r_wait_home;
            endcase
        end
    end

    // Sequencer state and latched commands advance on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= ST_IDLE;
            r_start   <= '0;
            r_level   <= LEVEL_HIGH;
            r_cont    <= 1'b0;
            r_rot_out <= 1'b0;
            r_toggle  <= 1'b0;
            r_rot_en  <= 1'b1;
            r_rot_ref <= DEG_ZERO;
            r_hgt_en  <= 1'b0;
            r_hgt_ref <= DEG_ZERO;
            r_cat_en  <= 1'b0;
            r_cat_ref <= DEG_ZERO;
            r_valve   <= 1'b0;
            r_relay   <= 1'b0;
        end else if (in_fire) begin
            r_step    <= n_step;
            r_start   <= n_start;
            r_level   <= n_level;
            r_cont    <= n_cont;
            r_rot_out <= n_rot_out;
            r_toggle  <= n_toggle;
            r_rot_en  <= n_rot_en;
            r_rot_ref <= n_rot_ref;
            r_hgt_en  <= n_hgt_en;
            r_hgt_ref <= n_hgt_ref;
            r_cat_en  <= n_cat_en;
            r_cat_ref <= n_cat_ref;
            r_valve   <= n_valve;
            r_relay   <= n_relay;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out.accepted      <= n_accepted;
            r_out.busy_res      <= (n_step != ST_IDLE);
            r_out.step_code     <= n_step;
            r_out.rotate_enable <= n_rot_en;
            r_out.rotate_ref    <= n_rot_ref;
            r_out.height_enable <= n_hgt_en;
            r_out.height_ref    <= n_hgt_ref;
            r_out.catch_enable  <= n_cat_en;
            r_out.catch_ref     <= n_cat_ref;
            r_out.valve_open    <= n_valve;
            r_out.pump_on       <= n_relay;
        end
    end

    // Every taken event leaves a result behind.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("no result after an input transfer");

    // Busy in the result agrees with the reported step.
    a_busy_matches_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.busy_res == (r_out.step_code != ST_IDLE)))
        else $error("busy disagrees with step code");

    // A taken start always lands in the rotate step.
    a_start_enters_rotate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.accepted) |-> (r_out.step_code == ST_ROTATE))
        else $error("accepted start not in rotate step");

    // A start with an invalid level is never taken.
    a_invalid_level_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.operation == OP_START && i_in.level == LEVEL_INVALID)
        |=> !r_out.accepted)
        else $error("start with invalid level was taken");

endmodule
